[rtl/eegp_pkg.sv]
// Shared types and constants for the EEG packet parser.
// No dependencies; imported by every module of the block.
`default_nettype none

package eegp_pkg;

  localparam int BAND_W   = 24;
  localparam int CFG_IDX_W = 4;
  localparam int Q_DEPTH  = 2;

  localparam logic [7:0] QUALITY_DEFAULT = 8'd200;
  localparam logic [7:0] RAW_ROW_LEN     = 8'd2;
  localparam logic [7:0] BAND_ROW_LEN    = 8'd24;

  localparam logic [7:0] SYNC_FIRST_RST  = 8'd170;
  localparam logic [7:0] SYNC_SECOND_RST = 8'd170;
  localparam logic [6:0] CODE_QUAL_RST   = 7'd2;
  localparam logic [6:0] CODE_ATTN_RST   = 7'd4;
  localparam logic [6:0] CODE_MED_RST    = 7'd5;
  localparam logic [7:0] CODE_RAW_RST    = 8'd128;
  localparam logic [7:0] CODE_BAND_RST   = 8'd131;
  localparam logic [7:0] MAX_PAYLOAD_RST = 8'd169;

  localparam logic [CFG_IDX_W-1:0] REG_SYNC_FIRST  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SYNC_SECOND = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CODE_QUAL   = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CODE_ATTN   = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CODE_MED    = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CODE_RAW    = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_CODE_BAND   = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_PAYLOAD = 4'd7;

  localparam logic [3:0] KIND_QUALITY    = 4'd0;
  localparam logic [3:0] KIND_ATTENTION  = 4'd1;
  localparam logic [3:0] KIND_MEDITATION = 4'd2;
  localparam logic [3:0] KIND_RAW        = 4'd3;
  localparam logic [3:0] KIND_BAND0      = 4'd4;

  // Per-packet values committed on a good checksum (bands travel separately).
  typedef struct packed {
    logic [7:0]  quality;
    logic [7:0]  attention;
    logic [7:0]  meditation;
    logic [15:0] raw;
    logic        raw_seen;
    logic        band_seen;
  } snap_t;

endpackage

`default_nettype wire

[rtl/eegp_front.sv]
// Front end: configuration registers, frame hunting, row parsing, checksum.
// Uses eegp_pkg; pushes one snapshot per good packet into eegp_snapq.
`default_nettype none

module eegp_front import eegp_pkg::*; #(
  parameter int BAND_COUNT = 8
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cfg_valid,
  input  wire logic [CFG_IDX_W-1:0]         cfg_index,
  input  wire logic [7:0]                   cfg_data,
  input  wire logic                         push,
  input  wire logic [7:0]                   rx_byte,
  output logic                              full,
  input  wire logic                         q_full,
  output logic                              q_push,
  output snap_t                             q_snap,
  output logic [BAND_COUNT*BAND_W-1:0]      q_bands
);

  localparam int BSEL_W = (BAND_COUNT > 1) ? $clog2(BAND_COUNT) : 1;

  typedef enum logic [2:0] {
    PH_SYNC1, PH_SYNC2, PH_LEN, PH_PAYLOAD, PH_CHECK
  } frame_phase_t;

  typedef enum logic [1:0] {
    ROW_CODE, ROW_LEN, ROW_SINGLE, ROW_DATA
  } row_phase_t;

  logic [7:0] sync_first, sync_second, code_raw_wave, code_band_power, max_payload;
  logic [6:0] code_quality, code_attn, code_med;

  frame_phase_t frame_phase;
  row_phase_t   row_phase;
  logic [7:0]   payload_length, payload_count, checksum_sum;
  logic [7:0]   row_code, row_remaining, row_length;
  logic [23:0]  assembly_word;
  logic [1:0]   tri_cnt;
  logic [2:0]   band_idx;
  logic [7:0]   pending_quality, pending_attention, pending_meditation;
  logic [15:0]  pending_raw;
  logic         raw_seen, band_seen;
  logic [BAND_W-1:0] band_store [BAND_COUNT];

  logic        accept;
  logic [23:0] asm_shift;
  logic [7:0]  count_next, remaining_next;
  logic        band_ok;
  logic        band_row_hit;

  assign full       = (frame_phase == PH_CHECK) && q_full;
  assign accept     = push && !full;
  assign asm_shift  = {assembly_word[15:0], rx_byte};
  assign count_next = payload_count + 8'd1;
  assign remaining_next = row_remaining - 8'd1;
  assign band_ok    = {1'b0, band_idx} < 4'(BAND_COUNT);
  // raw code wins when both codes match
  assign band_row_hit = (row_code != code_raw_wave) && (row_code == code_band_power) &&
                        (row_length == BAND_ROW_LEN);

  assign q_push = accept && (frame_phase == PH_CHECK) && (rx_byte == ~checksum_sum);
  assign q_snap = '{quality: pending_quality, attention: pending_attention,
                    meditation: pending_meditation, raw: pending_raw,
                    raw_seen: raw_seen, band_seen: band_seen};

  always_comb begin
    for (int i = 0; i < BAND_COUNT; i++) begin
      q_bands[i*BAND_W +: BAND_W] = band_store[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sync_first      <= SYNC_FIRST_RST;
      sync_second     <= SYNC_SECOND_RST;
      code_quality    <= CODE_QUAL_RST;
      code_attn       <= CODE_ATTN_RST;
      code_med        <= CODE_MED_RST;
      code_raw_wave   <= CODE_RAW_RST;
      code_band_power <= CODE_BAND_RST;
      max_payload     <= MAX_PAYLOAD_RST;
      frame_phase     <= PH_SYNC1;
      row_phase       <= ROW_CODE;
      payload_length  <= '0;
      payload_count   <= '0;
      checksum_sum    <= '0;
      row_code        <= '0;
      row_remaining   <= '0;
      row_length      <= '0;
      assembly_word   <= '0;
      tri_cnt         <= '0;
      band_idx        <= '0;
      pending_quality <= QUALITY_DEFAULT;
      pending_attention  <= '0;
      pending_meditation <= '0;
      pending_raw     <= '0;
      raw_seen        <= 1'b0;
      band_seen       <= 1'b0;
      for (int i = 0; i < BAND_COUNT; i++) begin
        band_store[i] <= '0;
      end
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          REG_SYNC_FIRST:  sync_first      <= cfg_data;
          REG_SYNC_SECOND: sync_second     <= cfg_data;
          REG_CODE_QUAL:   code_quality    <= cfg_data[6:0];
          REG_CODE_ATTN:   code_attn       <= cfg_data[6:0];
          REG_CODE_MED:    code_med        <= cfg_data[6:0];
          REG_CODE_RAW:    code_raw_wave   <= cfg_data;
          REG_CODE_BAND:   code_band_power <= cfg_data;
          REG_MAX_PAYLOAD: max_payload     <= cfg_data;
          default: ;
        endcase
      end

      if (accept) begin
        case (frame_phase)
          PH_SYNC1: begin
            if (rx_byte == sync_first) frame_phase <= PH_SYNC2;
          end
          PH_SYNC2: begin
            frame_phase <= (rx_byte == sync_second) ? PH_LEN : PH_SYNC1;
          end
          PH_LEN: begin
            if (rx_byte > max_payload) begin
              frame_phase <= PH_SYNC1;
            end else begin
              payload_length     <= rx_byte;
              payload_count      <= '0;
              checksum_sum       <= '0;
              row_phase          <= ROW_CODE;
              row_code           <= '0;
              row_remaining      <= '0;
              row_length         <= '0;
              assembly_word      <= '0;
              raw_seen           <= 1'b0;
              band_seen          <= 1'b0;
              pending_quality    <= QUALITY_DEFAULT;
              pending_attention  <= '0;
              pending_meditation <= '0;
              frame_phase <= (rx_byte == 8'd0) ? PH_CHECK : PH_PAYLOAD;
            end
          end
          PH_PAYLOAD: begin
            checksum_sum  <= checksum_sum + rx_byte;
            payload_count <= count_next;
            if (count_next >= payload_length) frame_phase <= PH_CHECK;
            case (row_phase)
              ROW_CODE: begin
                row_code  <= rx_byte;
                row_phase <= rx_byte[7] ? ROW_LEN : ROW_SINGLE;
              end
              ROW_SINGLE: begin
                if (row_code == {1'b0, code_quality}) begin
                  pending_quality <= rx_byte;
                end else if (row_code == {1'b0, code_attn}) begin
                  pending_attention <= rx_byte;
                end else if (row_code == {1'b0, code_med}) begin
                  pending_meditation <= rx_byte;
                end
                row_phase <= ROW_CODE;
              end
              ROW_LEN: begin
                row_length    <= rx_byte;
                row_remaining <= rx_byte;
                assembly_word <= '0;
                tri_cnt       <= '0;
                band_idx      <= '0;
                row_phase     <= (rx_byte == 8'd0) ? ROW_CODE : ROW_DATA;
              end
              ROW_DATA: begin
                assembly_word <= (band_row_hit && tri_cnt == 2'd2) ? '0 : asm_shift;
                if (row_code == code_raw_wave) begin
                  if (row_length == RAW_ROW_LEN && row_remaining == 8'd1) begin
                    pending_raw <= asm_shift[15:0];
                    raw_seen    <= 1'b1;
                  end
                end else if (band_row_hit) begin
                  if (tri_cnt == 2'd2 && band_ok) begin
                    band_store[band_idx[BSEL_W-1:0]] <= asm_shift;
                  end
                  if (row_remaining == 8'd1) band_seen <= 1'b1;
                end
                if (tri_cnt == 2'd2) begin
                  tri_cnt  <= '0;
                  band_idx <= band_idx + 3'd1;
                end else begin
                  tri_cnt <= tri_cnt + 2'd1;
                end
                row_remaining <= remaining_next;
                if (remaining_next == 8'd0) row_phase <= ROW_CODE;
              end
              default: row_phase <= ROW_CODE;
            endcase
          end
          default: frame_phase <= PH_SYNC1;
        endcase
      end
    end
  end

endmodule

`default_nettype wire

[rtl/eegp_snapq.sv]
// Two-entry queue of committed packet snapshots between front and back.
// Uses eegp_pkg for the snapshot type.
`default_nettype none

module eegp_snapq import eegp_pkg::*; #(
  parameter int BAND_COUNT = 8
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         wr_en,
  input  wire snap_t                        wr_snap,
  input  wire logic [BAND_COUNT*BAND_W-1:0] wr_bands,
  output logic                              q_full,
  output logic                              rd_valid,
  input  wire logic                         rd_en,
  output snap_t                             rd_snap,
  output logic [BAND_COUNT*BAND_W-1:0]      rd_bands
);

  snap_t                         snap_mem [Q_DEPTH];
  logic [BAND_COUNT*BAND_W-1:0]  band_mem [Q_DEPTH];
  logic                          wr_ptr, rd_ptr;
  logic [1:0]                    count;

  assign q_full   = (count == 2'(Q_DEPTH));
  assign rd_valid = (count != 2'd0);
  assign rd_snap  = snap_mem[rd_ptr];
  assign rd_bands = band_mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      snap_mem[wr_ptr] <= wr_snap;
      band_mem[wr_ptr] <= wr_bands;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (wr_en) wr_ptr <= ~wr_ptr;
      if (rd_en) rd_ptr <= ~rd_ptr;
      if (wr_en && !rd_en) begin
        count <= count + 2'd1;
      end else if (rd_en && !wr_en) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

`default_nettype wire

[rtl/eegp_back.sv]
// Back end: walks the head snapshot and presents one result per cycle while pop is high.
// Uses eegp_pkg; reads from eegp_snapq.
`default_nettype none

module eegp_back import eegp_pkg::*; #(
  parameter int BAND_COUNT = 8
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         rd_valid,
  input  wire snap_t                        rd_snap,
  input  wire logic [BAND_COUNT*BAND_W-1:0] rd_bands,
  output logic                              rd_en,
  input  wire logic                         pop,
  output logic                              empty,
  output logic [3:0]                        value_kind,
  output logic signed [24:0]                value_data,
  output logic                              last_value
);

  localparam int BSEL_W = (BAND_COUNT > 1) ? $clog2(BAND_COUNT) : 1;
  localparam logic [3:0] KIND_LAST_BAND = 4'(4 + BAND_COUNT - 1);

  logic [3:0]        kind;
  logic [3:0]        kind_next;
  logic [3:0]        band_off;
  logic [BSEL_W-1:0] bsel;
  logic              take;

  assign empty      = !rd_valid;
  assign take       = pop && rd_valid;
  assign value_kind = kind;
  assign band_off   = kind - KIND_BAND0;
  assign bsel       = band_off[BSEL_W-1:0];

  always_comb begin
    case (kind)
      KIND_QUALITY:    value_data = {17'd0, rd_snap.quality};
      KIND_ATTENTION:  value_data = {17'd0, rd_snap.attention};
      KIND_MEDITATION: value_data = {17'd0, rd_snap.meditation};
      KIND_RAW:        value_data = {{9{rd_snap.raw[15]}}, rd_snap.raw};
      default:         value_data = {1'b0, rd_bands[bsel*BAND_W +: BAND_W]};
    endcase
  end

  always_comb begin
    last_value = (kind == KIND_LAST_BAND) ||
                 (kind == KIND_RAW && !rd_snap.band_seen) ||
                 (kind == KIND_MEDITATION && !rd_snap.raw_seen && !rd_snap.band_seen);
    if (kind == KIND_MEDITATION) begin
      kind_next = rd_snap.raw_seen ? KIND_RAW : KIND_BAND0;
    end else begin
      kind_next = kind + 4'd1;
    end
  end

  assign rd_en = take && last_value;

  always_ff @(posedge clk) begin
    if (rst) begin
      kind <= KIND_QUALITY;
    end else if (take) begin
      kind <= last_value ? KIND_QUALITY : kind_next;
    end
  end

endmodule

`default_nettype wire

[rtl/eeg_packet_parser.sv]
// EEG serial packet parser: one received byte per cycle while full is low, results on a pop queue.
// Latency: results of a packet are visible the cycle after its checksum byte
// when no earlier results wait. Throughput: one byte and one result per cycle;
// full is high only while a checksum byte is due and two committed packets wait.
// Reset (rst, synchronous): registers to defaults, parser hunting, queue empty.
// Uses eegp_pkg, eegp_front, eegp_snapq, eegp_back.
`default_nettype none

module eeg_packet_parser import eegp_pkg::*; #(
  parameter int BAND_COUNT = 8
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [7:0]           cfg_data,
  input  wire logic                 push,
  output logic                      full,
  input  wire logic [7:0]           rx_byte,
  input  wire logic                 pop,
  output logic                      empty,
  output logic [3:0]                value_kind,
  output logic signed [24:0]        value_data,
  output logic                      last_value
);

  logic                         q_full, q_push, rd_valid, rd_en;
  snap_t                        q_snap, rd_snap;
  logic [BAND_COUNT*BAND_W-1:0] q_bands, rd_bands;

  assign cfg_ready = 1'b1;

  eegp_front #(.BAND_COUNT(BAND_COUNT)) u_front (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .push(push), .rx_byte(rx_byte), .full(full),
    .q_full(q_full), .q_push(q_push), .q_snap(q_snap), .q_bands(q_bands)
  );

  eegp_snapq #(.BAND_COUNT(BAND_COUNT)) u_snapq (
    .clk(clk), .rst(rst),
    .wr_en(q_push), .wr_snap(q_snap), .wr_bands(q_bands), .q_full(q_full),
    .rd_valid(rd_valid), .rd_en(rd_en), .rd_snap(rd_snap), .rd_bands(rd_bands)
  );

  eegp_back #(.BAND_COUNT(BAND_COUNT)) u_back (
    .clk(clk), .rst(rst),
    .rd_valid(rd_valid), .rd_snap(rd_snap), .rd_bands(rd_bands), .rd_en(rd_en),
    .pop(pop), .empty(empty),
    .value_kind(value_kind), .value_data(value_data), .last_value(last_value)
  );

`ifndef SYNTHESIS
  a_kind_range: assert property (@(posedge clk) disable iff (rst)
    !empty |-> value_kind <= 4'(4 + BAND_COUNT - 1))
    else $error("result kind out of range");

  a_new_packet_starts_quality: assert property (@(posedge clk) disable iff (rst)
    (pop && !empty && last_value) |=> (empty || value_kind == KIND_QUALITY))
    else $error("packet does not start with quality");

  a_full_needs_backlog: assert property (@(posedge clk) disable iff (rst)
    full |-> !empty)
    else $error("full raised with no results waiting");

  a_no_push_when_queue_full: assert property (@(posedge clk) disable iff (rst)
    q_full |-> !q_push)
    else $error("snapshot written into full queue");
`endif

endmodule

`default_nettype wire

[tb/sv/eegp_readings_pkg.sv]
// Scoreboard for the EEG packet parser: a byte-level model of the framing,
// row parsing and checksum, with a queue of the readings each packet yields.
// Depends on eegp_pkg for widths, register indexes and reading kinds.
package eegp_readings_pkg;
  import eegp_pkg::*;

  typedef enum logic [2:0] {FR_SYNC1, FR_SYNC2, FR_LEN, FR_BODY, FR_CHECK} frame_phase_t;
  typedef enum logic [1:0] {RW_CODE, RW_LEN, RW_SINGLE, RW_DATA} row_phase_t;

  localparam int MAX_BANDS = 8;

  typedef struct packed {
    logic [3:0]         kind;
    logic signed [24:0] data;
    logic               last;
  } reading_t;

  class reading_scoreboard;
    logic [7:0] sync_first, sync_second, code_raw, code_band, max_len;
    logic [6:0] code_qual, code_attn, code_med;

    frame_phase_t frame;
    row_phase_t   row;
    logic [7:0]   pkt_len, pkt_cnt, pkt_sum;
    logic [7:0]   row_code, row_left, row_len;
    logic [23:0]  word;
    logic [7:0]   quality, attention, meditation;
    logic [15:0]  raw;
    logic [BAND_W-1:0] bands [MAX_BANDS];
    logic         raw_seen, band_seen;

    reading_t due_readings[$];
    int errors;
    int band_count;

    function new(int n_bands);
      band_count  = n_bands;
      sync_first  = SYNC_FIRST_RST;
      sync_second = SYNC_SECOND_RST;
      code_qual   = CODE_QUAL_RST;
      code_attn   = CODE_ATTN_RST;
      code_med    = CODE_MED_RST;
      code_raw    = CODE_RAW_RST;
      code_band   = CODE_BAND_RST;
      max_len     = MAX_PAYLOAD_RST;
      frame       = FR_SYNC1;
      row         = RW_CODE;
      pkt_len     = '0;
      pkt_cnt     = '0;
      pkt_sum     = '0;
      row_code    = '0;
      row_left    = '0;
      row_len     = '0;
      word        = '0;
      quality     = QUALITY_DEFAULT;
      attention   = '0;
      meditation  = '0;
      raw         = '0;
      raw_seen    = 1'b0;
      band_seen   = 1'b0;
      foreach (bands[i]) bands[i] = '0;
      errors      = 0;
    endfunction

    function int pending();
      return due_readings.size();
    endfunction

    task report(string what, int want, int got);
      $display("%0t mismatch %s: expected %0h got %0h", $time, what, want, got);
      errors++;
    endtask

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] val);
      case (idx)
        REG_SYNC_FIRST:  sync_first  = val;
        REG_SYNC_SECOND: sync_second = val;
        REG_CODE_QUAL:   code_qual   = val[6:0];
        REG_CODE_ATTN:   code_attn   = val[6:0];
        REG_CODE_MED:    code_med    = val[6:0];
        REG_CODE_RAW:    code_raw    = val;
        REG_CODE_BAND:   code_band   = val;
        REG_MAX_PAYLOAD: max_len     = val;
        default: ;
      endcase
    endfunction

    function void queue_reading(logic [3:0] kind, logic [24:0] data);
      reading_t r;
      r.kind = kind;
      r.data = data;
      r.last = 1'b0;
      due_readings.push_back(r);
    endfunction

    function void row_step(logic [7:0] b);
      logic [7:0] pos;
      int band;
      case (row)
        RW_CODE: begin
          row_code = b;
          row = b[7] ? RW_LEN : RW_SINGLE;
        end
        RW_SINGLE: begin
          if (row_code == {1'b0, code_qual}) quality = b;
          else if (row_code == {1'b0, code_attn}) attention = b;
          else if (row_code == {1'b0, code_med}) meditation = b;
          row = RW_CODE;
        end
        RW_LEN: begin
          row_len  = b;
          row_left = b;
          word     = '0;
          row = (b == 8'd0) ? RW_CODE : RW_DATA;
        end
        default: begin
          pos  = row_len - row_left;
          word = {word[15:0], b};
          if (row_code == code_raw) begin
            if (row_len == RAW_ROW_LEN && row_left == 8'd1) begin
              raw      = word[15:0];
              raw_seen = 1'b1;
            end
          end else if (row_code == code_band && row_len == BAND_ROW_LEN) begin
            if (pos % 3 == 2) begin
              band = pos / 3;
              if (band < band_count && band < MAX_BANDS) bands[band] = word;
              word = '0;
            end
            if (row_left == 8'd1) band_seen = 1'b1;
          end
          row_left = row_left - 8'd1;
          if (row_left == 8'd0) row = RW_CODE;
        end
      endcase
    endfunction

    // One accepted rx byte; a good checksum byte queues the packet's readings.
    function void take_byte(logic [7:0] b);
      reading_t r;
      case (frame)
        FR_SYNC1: if (b == sync_first) frame = FR_SYNC2;
        FR_SYNC2: frame = (b == sync_second) ? FR_LEN : FR_SYNC1;
        FR_LEN: begin
          if (b > max_len) begin
            frame = FR_SYNC1;
          end else begin
            pkt_len    = b;
            pkt_cnt    = '0;
            pkt_sum    = '0;
            row        = RW_CODE;
            row_code   = '0;
            row_left   = '0;
            row_len    = '0;
            word       = '0;
            raw_seen   = 1'b0;
            band_seen  = 1'b0;
            quality    = QUALITY_DEFAULT;
            attention  = '0;
            meditation = '0;
            frame = (b == 8'd0) ? FR_CHECK : FR_BODY;
          end
        end
        FR_BODY: begin
          pkt_sum = pkt_sum + b;
          row_step(b);
          pkt_cnt = pkt_cnt + 8'd1;
          if (pkt_cnt >= pkt_len) frame = FR_CHECK;
        end
        default: begin
          frame = FR_SYNC1;
          if (b == ~pkt_sum) begin
            queue_reading(KIND_QUALITY, {17'd0, quality});
            queue_reading(KIND_ATTENTION, {17'd0, attention});
            queue_reading(KIND_MEDITATION, {17'd0, meditation});
            if (raw_seen) queue_reading(KIND_RAW, {{9{raw[15]}}, raw});
            if (band_seen) begin
              for (int i = 0; i < band_count && i < MAX_BANDS; i++) begin
                queue_reading(KIND_BAND0 + 4'(i), {1'b0, bands[i]});
              end
            end
            r = due_readings.pop_back();
            r.last = 1'b1;
            due_readings.push_back(r);
          end
        end
      endcase
    endfunction

    task check_reading(logic [3:0] kind, logic [24:0] data, logic last);
      reading_t want;
      if (due_readings.size() == 0) begin
        report("unexpected reading kind", -1, kind);
        return;
      end
      want = due_readings.pop_front();
      if (kind !== want.kind) report("value_kind", want.kind, kind);
      if (data !== want.data) report("value_data", want.data, data);
      if (last !== want.last) report("last_value", want.last, last);
    endtask
  endclass

endpackage

[tb/sv/tb_top.sv]
// Top-level testbench for eeg_packet_parser: directed and random byte streams,
// randomized push/pop pacing and register settings, checked by the scoreboard.
// Depends on eegp_pkg, eegp_readings_pkg and the parser RTL.
module tb_top;
  import eegp_pkg::*;
  import eegp_readings_pkg::*;

  localparam int N_BANDS      = 8;
  localparam int DRAIN_CYCLES = 8;
  localparam int LONG_HOLD    = 400;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 4'd8;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 4'd15;

  logic                 clk;
  logic                 rst;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [7:0]           cfg_data;
  logic                 push;
  logic                 full;
  logic [7:0]           rx_byte;
  logic                 pop;
  logic                 empty;
  logic [3:0]           value_kind;
  logic signed [24:0]   value_data;
  logic                 last_value;

  reading_scoreboard sb;
  logic [7:0] pkt_q[$];
  int bytes_sent    = 0;
  int readings_done = 0;
  int burst_left    = 0;
  bit no_gaps       = 1'b0;
  bit hold_req      = 1'b0;

  eeg_packet_parser #(.BAND_COUNT(N_BANDS)) i_dut (.*);

  initial clk = 1'b0;
  always #5 clk = ~clk;

  initial begin
    #2000000;
    $display("TB_ERROR");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (push && !full) sb.take_byte(rx_byte);
      if (pop && !empty) begin
        sb.check_reading(value_kind, value_data, last_value);
        readings_done++;
      end
      if (cfg_valid && cfg_ready) sb.set_reg(cfg_index, cfg_data);
    end
  end

  // Result side: pop pattern changes after a span of random length; one long hold on request.
  initial begin
    int span;
    int mode;
    span = 0;
    mode = 0;
    pop <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        pop <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_req = 1'b0;
      end
      if (span == 0) begin
        span = $urandom_range(8, 64);
        mode = $urandom_range(0, 3);
      end
      span--;
      case (mode)
        0: pop <= 1'b1;
        1: pop <= 1'($urandom_range(0, 1));
        2: pop <= (span % 4 == 0);
        default: pop <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  function automatic logic [7:0] rnd_byte();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic idle_sender(input int n);
    push <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic send_byte(input logic [7:0] b);
    push    <= 1'b1;
    rx_byte <= b;
    @(posedge clk);
    while (full) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_queue();
    foreach (pkt_q[k]) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        if (!no_gaps) idle_sender($urandom_range(1, 6));
      end
      burst_left--;
      send_byte(pkt_q[k]);
    end
    pkt_q.delete();
  endtask

  task automatic drain();
    push <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic configure(input logic [7:0] s1, s2, cq, ca, cm, craw, cband, maxp);
    write_reg(REG_SYNC_FIRST, s1);
    write_reg(REG_SYNC_SECOND, s2);
    write_reg(REG_CODE_QUAL, cq);
    write_reg(REG_CODE_ATTN, ca);
    write_reg(REG_CODE_MED, cm);
    write_reg(REG_CODE_RAW, craw);
    write_reg(REG_CODE_BAND, cband);
    write_reg(REG_MAX_PAYLOAD, maxp);
    cfg_valid <= 1'b0;
  endtask

  task automatic build_packet(input bit good_sum, input bit with_bands);
    logic [7:0] body[$];
    logic [7:0] band_row[$];
    logic [7:0] sum;
    int n_rows;
    int n;
    bit bands_first;
    band_row = {sb.code_band, BAND_ROW_LEN};
    repeat (24) band_row.push_back(rnd_byte());
    bands_first = 1'($urandom_range(0, 1));
    if (with_bands && bands_first) body = band_row;
    n_rows = $urandom_range(0, 5);
    for (int r = 0; r < n_rows; r++) begin
      case ($urandom_range(0, 7))
        0: body = {body, {1'b0, sb.code_qual}, rnd_byte()};
        1: body = {body, {1'b0, sb.code_attn}, rnd_byte()};
        2: body = {body, {1'b0, sb.code_med}, rnd_byte()};
        3: body = {body, sb.code_raw, RAW_ROW_LEN, rnd_byte(), rnd_byte()};
        4: begin
          n = $urandom_range(0, 3);
          if (n == 2) n = 1;
          body = {body, sb.code_raw, 8'(n)};
          repeat (n) body.push_back(rnd_byte());
        end
        5: begin
          n = $urandom_range(0, 4);
          body = {body, sb.code_band, 8'(n)};
          repeat (n) body.push_back(rnd_byte());
        end
        6: body = {body, 8'($urandom_range(0, 127)), rnd_byte()};
        default: begin
          n = $urandom_range(0, 4);
          body = {body, 8'($urandom_range(128, 255)), 8'(n)};
          repeat (n) body.push_back(rnd_byte());
        end
      endcase
    end
    if (with_bands && !bands_first) body = {body, band_row};
    // over-long packets are either cut to fit (partial last row) or left to be dropped
    if (body.size() > sb.max_len && $urandom_range(0, 1) == 1) begin
      while (body.size() > sb.max_len) void'(body.pop_back());
    end
    sum = '0;
    foreach (body[k]) sum = sum + body[k];
    pkt_q = {pkt_q, sb.sync_first, sb.sync_second, 8'(body.size())};
    foreach (body[k]) pkt_q.push_back(body[k]);
    pkt_q.push_back(good_sum ? ~sum : ~sum ^ 8'($urandom_range(1, 255)));
  endtask

  task automatic run_random(input int n_items, input int min_readings);
    int start_bytes;
    int start_reads;
    int pick;
    start_bytes = bytes_sent;
    start_reads = readings_done;
    while (bytes_sent - start_bytes < n_items ||
           readings_done - start_reads < min_readings) begin
      pick    = $urandom_range(0, 19);
      no_gaps = ($urandom_range(0, 3) == 0);
      if (pick < 13) begin
        build_packet(1'b1, $urandom_range(0, 4) == 0);
      end else if (pick < 15) begin
        build_packet(1'b0, $urandom_range(0, 4) == 0);
      end else if (pick < 17) begin
        build_packet(1'b1, 1'b0);
        pick = $urandom_range(1, pkt_q.size() - 1);
        while (pkt_q.size() > pick) void'(pkt_q.pop_back());
      end else begin
        repeat ($urandom_range(1, 6)) pkt_q.push_back(rnd_byte());
      end
      send_queue();
    end
  endtask

  initial begin
    sb = new(N_BANDS);
    rst       <= 1'b1;
    push      <= 1'b0;
    rx_byte   <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= REG_SYNC_FIRST;
    cfg_data  <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    configure(SYNC_FIRST_RST, SYNC_SECOND_RST, {1'b0, CODE_QUAL_RST}, {1'b0, CODE_ATTN_RST},
              {1'b0, CODE_MED_RST}, CODE_RAW_RST, CODE_BAND_RST, MAX_PAYLOAD_RST);

    // empty packet, second-sync miss, over-long length, field extremes with
    // negative raw, attention row cut off by the payload end
    pkt_q = {SYNC_FIRST_RST, SYNC_SECOND_RST, 8'h00, 8'hFF,
             SYNC_FIRST_RST, 8'h55,
             SYNC_FIRST_RST, SYNC_SECOND_RST, MAX_PAYLOAD_RST + 8'd1,
             SYNC_FIRST_RST, SYNC_SECOND_RST, 8'd10,
             {1'b0, CODE_QUAL_RST}, 8'h00, {1'b0, CODE_ATTN_RST}, 8'hFF,
             {1'b0, CODE_MED_RST}, 8'h7F, CODE_RAW_RST, RAW_ROW_LEN, 8'h80, 8'h00, 8'h74,
             SYNC_FIRST_RST, SYNC_SECOND_RST, 8'd1, {1'b0, CODE_ATTN_RST}, 8'hFB};
    send_queue();
    run_random(45, 12);

    // results held back while packets keep arriving, then a full drain
    hold_req = 1'b1;
    repeat (5) pkt_q = {pkt_q, sb.sync_first, sb.sync_second, 8'h00, 8'hFF};
    send_queue();
    drain();

    // masked codes, meditation code equal to quality, widest payload
    configure(8'h00, 8'hFF, 8'hFF, 8'h80, 8'h7F, 8'hFF, 8'h80, 8'hFF);
    run_random(45, 16);
    drain();

    // writes to unused indexes; attention equals meditation, raw equals band
    write_reg(REG_SPARE_LO, 8'h01);
    write_reg(REG_SPARE_HI, 8'hFF);
    configure(8'hFF, 8'h00, 8'h00, 8'h33, 8'h33, 8'h90, 8'h90, 8'd40);
    run_random(30, 8);
    drain();

    configure(8'h55, 8'hAA, {1'b0, CODE_QUAL_RST}, {1'b0, CODE_ATTN_RST},
              {1'b0, CODE_MED_RST}, CODE_RAW_RST, CODE_BAND_RST, 8'd1);
    run_random(20, 6);
    drain();

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/eegp_pkg.sv
rtl/eegp_front.sv
rtl/eegp_snapq.sv
rtl/eegp_back.sv
rtl/eeg_packet_parser.sv
tb/sv/eegp_readings_pkg.sv
tb/sv/tb_top.sv
